// File: rtl/core/ntp_pkg.sv
// Shared types, constants and table functions for the test pattern pixel pipeline.
package ntp_pkg;

    // Raster geometry
    localparam int unsigned FRAME_WIDTH  = 720;
    localparam int unsigned FRAME_HEIGHT = 480;
    localparam int unsigned ACTIVE_LEFT  = 4;
    localparam int unsigned ACTIVE_COLS  = 711;

    localparam int unsigned X_W    = 10;
    localparam int unsigned Y_W    = 9;
    localparam int unsigned C_W    = 10;
    localparam int unsigned MODE_W = 4;

    // Pattern select codes
    localparam logic [MODE_W-1:0] MODE_BARS100 = 4'd0;
    localparam logic [MODE_W-1:0] MODE_BARS75  = 4'd1;
    localparam logic [MODE_W-1:0] MODE_HRAMP   = 4'd2;
    localparam logic [MODE_W-1:0] MODE_VRAMP   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_CHECK8  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_CHECK16 = 4'd5;
    localparam logic [MODE_W-1:0] MODE_BLACK   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_WHITE   = 4'd7;
    localparam logic [MODE_W-1:0] MODE_PLUGE   = 4'd8;
    localparam logic [MODE_W-1:0] MODE_XHATCH  = 4'd9;

    typedef struct packed {
        logic [X_W-1:0] pixel_x;
        logic [Y_W-1:0] pixel_y;
    } t_pix_in;

    typedef struct packed {
        logic [C_W-1:0] luma;
        logic [C_W-1:0] chroma_blue;
        logic [C_W-1:0] chroma_red;
    } t_pix_out;

    localparam logic [C_W-1:0] LUMA_MIN    = 10'd48;
    localparam logic [C_W-1:0] LUMA_MAX    = 10'd940;
    localparam logic [C_W-1:0] CHROMA_MIN  = 10'd64;
    localparam logic [C_W-1:0] CHROMA_MAX  = 10'd960;
    localparam logic [C_W-1:0] CHROMA_ZERO = 10'd512;

    localparam t_pix_out COL_BLACK   = '{10'd64,  10'd512, 10'd512};
    localparam t_pix_out COL_WHITE   = '{10'd940, 10'd512, 10'd512};
    localparam t_pix_out COL_MINUS_I = '{10'd244, 10'd612, 10'd395};
    localparam t_pix_out COL_PLUS_Q  = '{10'd141, 10'd697, 10'd606};

    localparam logic [C_W-1:0] BAR_Y100 [7] =
        '{10'd940, 10'd840, 10'd678, 10'd578, 10'd426, 10'd326, 10'd164};
    localparam logic [C_W-1:0] BAR_CB100 [7] =
        '{10'd512, 10'd64, 10'd663, 10'd215, 10'd809, 10'd361, 10'd960};
    localparam logic [C_W-1:0] BAR_CR100 [7] =
        '{10'd512, 10'd585, 10'd64, 10'd137, 10'd887, 10'd960, 10'd439};
    localparam logic [C_W-1:0] BAR_Y75 [7] =
        '{10'd940, 10'd648, 10'd524, 10'd448, 10'd336, 10'd260, 10'd140};
    localparam logic [C_W-1:0] BAR_CB75 [7] =
        '{10'd512, 10'd176, 10'd624, 10'd288, 10'd736, 10'd400, 10'd848};
    localparam logic [C_W-1:0] BAR_CR75 [7] =
        '{10'd512, 10'd568, 10'd176, 10'd232, 10'd792, 10'd848, 10'd456};
    localparam logic [C_W-1:0] PLUGE_Y [5] =
        '{10'd64, 10'd48, 10'd64, 10'd80, 10'd64};

    // Split of a span into five patches, the remainder widening the first ones
    function automatic int unsigned patch_edge(input int unsigned i, input int unsigned w);
        int unsigned n;
        n = i + 1;
        return n * (w / 5) + ((n < (w % 5)) ? n : (w % 5));
    endfunction

    // Bar boundaries: first column of bar k is ceil(k*AW/7)
    function automatic int unsigned bar_edge(input int unsigned k);
        return (k * ACTIVE_COLS + 6) / 7;
    endfunction

    localparam logic [X_W-1:0] BAR_EDGE [6] = '{
        X_W'(bar_edge(1)), X_W'(bar_edge(2)), X_W'(bar_edge(3)),
        X_W'(bar_edge(4)), X_W'(bar_edge(5)), X_W'(bar_edge(6))};

    localparam logic [Y_W-1:0] Y_TOP_END  = Y_W'((4 * FRAME_HEIGHT + 3) / 6);
    localparam logic [Y_W-1:0] Y_CAST_END = Y_W'((3 * FRAME_HEIGHT + 2) / 4);

    // Lower band quarter blocks
    localparam int unsigned QB_BASE = ACTIVE_COLS / 4;
    localparam int unsigned QB_REM  = ACTIVE_COLS % 4;
    localparam int unsigned QB_E0   = QB_BASE + ((QB_REM > 0) ? 1 : 0);
    localparam int unsigned QB_E1   = QB_E0 + QB_BASE + ((QB_REM > 1) ? 1 : 0);
    localparam int unsigned QB_E2   = QB_E1 + QB_BASE + ((QB_REM > 2) ? 1 : 0);
    localparam int unsigned QB_PW   = (ACTIVE_COLS > QB_E2) ? ACTIVE_COLS - QB_E2 : 1;

    localparam logic [X_W-1:0] BAR_PATCH_EDGE [4] = '{
        X_W'(patch_edge(0, QB_PW)), X_W'(patch_edge(1, QB_PW)),
        X_W'(patch_edge(2, QB_PW)), X_W'(patch_edge(3, QB_PW))};

    // PLUGE window
    localparam int unsigned WIN_X0 = ACTIVE_LEFT + (2 * ACTIVE_COLS + 5) / 10;
    localparam int unsigned WIN_XE = ACTIVE_LEFT + (8 * ACTIVE_COLS + 5) / 10;
    localparam int unsigned WIN_Y0 = (3 * FRAME_HEIGHT + 2) / 4;
    localparam int unsigned WIN_YE = (7 * FRAME_HEIGHT + 4) / 8;
    localparam bit          WIN_OK = (WIN_XE > WIN_X0) && (WIN_YE > WIN_Y0);
    localparam int unsigned WIN_W  = WIN_OK ? WIN_XE - WIN_X0 : 1;

    localparam logic [X_W-1:0] WIN_PATCH_EDGE [4] = '{
        X_W'(patch_edge(0, WIN_W)), X_W'(patch_edge(1, WIN_W)),
        X_W'(patch_edge(2, WIN_W)), X_W'(patch_edge(3, WIN_W))};

    // Crosshatch
    localparam int unsigned GRID_STEP_X = 79;
    localparam int unsigned GRID_STEP_Y = 60;
    localparam int unsigned GRID_NX     = (ACTIVE_COLS - 1) / GRID_STEP_X + 1;
    localparam int unsigned GRID_NY     = (FRAME_HEIGHT - 1) / GRID_STEP_Y + 1;

    // Ramps: Y = 64 + floor((1752*pos + span) / (2*span)), by reciprocal
    localparam int unsigned RAMP_BASE  = 64;
    localparam int unsigned RAMP_SCALE = 876;
    localparam int unsigned SPAN_H = (ACTIVE_COLS > 1) ? ACTIVE_COLS - 1 : 1;
    localparam int unsigned SPAN_V = (FRAME_HEIGHT > 1) ? FRAME_HEIGHT - 1 : 1;
    localparam int unsigned DIV_H  = 2 * SPAN_H;
    localparam int unsigned DIV_V  = 2 * SPAN_V;
    localparam int unsigned SPAN_MAX = (SPAN_H > SPAN_V) ? SPAN_H : SPAN_V;
    localparam int unsigned DIV_MAX  = 2 * SPAN_MAX;
    localparam int unsigned N_MAX    = 2 * RAMP_SCALE * SPAN_MAX + SPAN_MAX;
    localparam int unsigned N_W      = $clog2(N_MAX + 1);
    localparam int unsigned RECIP_SHIFT = N_W;
    localparam int unsigned RECIP_H  = (1 << N_W) / DIV_H;
    localparam int unsigned RECIP_V  = (1 << N_W) / DIV_V;
    localparam int unsigned M_W      = $clog2(((RECIP_H > RECIP_V) ? RECIP_H : RECIP_V) + 1);
    localparam int unsigned D_W      = $clog2(DIV_MAX + 1);
    localparam int unsigned Q_W      = $clog2(RAMP_SCALE + 1);
    localparam int unsigned P_W      = N_W + M_W;

    typedef struct packed {
        logic           ramp;
        logic           vert;
        logic [N_W-1:0] num;
        t_pix_out       colour;
    } t_s1;

    typedef struct packed {
        logic           ramp;
        logic           vert;
        logic [N_W-1:0] num;
        logic [P_W-1:0] prod;
        t_pix_out       colour;
    } t_s2;

    typedef struct packed {
        logic           ramp;
        logic           vert;
        logic [N_W-1:0] num;
        logic [Q_W-1:0] q_est;
        logic [N_W-1:0] qd;
        t_pix_out       colour;
    } t_s3;

    typedef struct packed {
        logic s2;
        logic s3;
    } t_div_en;

    function automatic logic [D_W-1:0] ramp_div(input logic vert);
        return vert ? D_W'(DIV_V) : D_W'(DIV_H);
    endfunction

    function automatic t_pix_out bar_colour(input logic [2:0] idx, input logic full);
        t_pix_out c;
        if (full) begin
            c = '{BAR_Y100[idx], BAR_CB100[idx], BAR_CR100[idx]};
        end else begin
            c = '{BAR_Y75[idx], BAR_CB75[idx], BAR_CR75[idx]};
        end
        return c;
    endfunction

    function automatic t_pix_out pluge_colour(input logic [2:0] idx);
        return '{PLUGE_Y[idx], CHROMA_ZERO, CHROMA_ZERO};
    endfunction

endpackage

// File: rtl/core/ntp_classify.sv
// First stage: coordinate decode, band and patch search, colour select, ramp numerator.
module ntp_classify
    import ntp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [MODE_W-1:0] i_mode,
    input  t_pix_in           i_pix,
    output t_s1               o_s1
);

    t_s1 r_s1;
    t_s1 n_s1;

    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic [X_W-1:0] ax;
    logic [X_W-1:0] bar_r;
    logic [X_W-1:0] win_r;
    logic [X_W-1:0] pos;
    logic [2:0]     bar;
    logic [2:0]     bar_patch;
    logic [2:0]     win_patch;
    logic           in_frame;
    logic           active;
    logic           in_win;
    logic           grid_hit;
    logic           full;
    t_pix_out       bars_col;

    always_comb begin
        x        = i_pix.pixel_x;
        y        = i_pix.pixel_y;
        in_frame = (32'(x) < FRAME_WIDTH) && (32'(y) < FRAME_HEIGHT);
        active   = (32'(x) >= ACTIVE_LEFT) && ((32'(x) - ACTIVE_LEFT) < ACTIVE_COLS);
        ax       = x - X_W'(ACTIVE_LEFT);
        full     = (i_mode == MODE_BARS100);

        // bar = min(6, ax*7/AW) as a count of crossed boundaries
        bar = 3'd0;
        for (int i = 0; i < 6; i++) begin
            if (ax >= BAR_EDGE[i]) begin
                bar = 3'(i + 1);
            end
        end

        bar_r     = ax - X_W'(QB_E2);
        bar_patch = 3'd0;
        for (int i = 0; i < 4; i++) begin
            if (bar_r >= BAR_PATCH_EDGE[i]) begin
                bar_patch = 3'(i + 1);
            end
        end

        if (y < Y_TOP_END) begin
            bars_col = bar_colour(bar, full);
        end else if (y < Y_CAST_END) begin
            bars_col = bar[0] ? COL_BLACK : bar_colour(3'd6 - bar, full);
        end else if (32'(ax) < QB_E0) begin
            bars_col = COL_MINUS_I;
        end else if (32'(ax) < QB_E1) begin
            bars_col = COL_WHITE;
        end else if (32'(ax) < QB_E2) begin
            bars_col = COL_PLUS_Q;
        end else begin
            bars_col = pluge_colour(bar_patch);
        end

        in_win = WIN_OK && (32'(x) >= WIN_X0) && (32'(x) < WIN_XE)
              && (32'(y) >= WIN_Y0) && (32'(y) < WIN_YE);
        win_r     = X_W'(32'(x) - WIN_X0);
        win_patch = 3'd0;
        for (int i = 0; i < 4; i++) begin
            if (win_r >= WIN_PATCH_EDGE[i]) begin
                win_patch = 3'(i + 1);
            end
        end

        grid_hit = (32'(ax) == ACTIVE_COLS - 1) || (32'(y) == FRAME_HEIGHT - 1);
        for (int i = 0; i < GRID_NX; i++) begin
            if (32'(ax) == i * GRID_STEP_X) begin
                grid_hit = 1'b1;
            end
        end
        for (int i = 0; i < GRID_NY; i++) begin
            if (32'(y) == i * GRID_STEP_Y) begin
                grid_hit = 1'b1;
            end
        end

        n_s1.colour = COL_BLACK;
        n_s1.ramp   = 1'b0;
        n_s1.vert   = (i_mode == MODE_VRAMP);
        if (in_frame) begin
            unique case (i_mode) inside
                MODE_WHITE: n_s1.colour = COL_WHITE;
                MODE_BLACK: n_s1.colour = COL_BLACK;
                MODE_PLUGE: begin
                    if (in_win) begin
                        n_s1.colour = pluge_colour(win_patch);
                    end
                end
                MODE_BARS100, MODE_BARS75: begin
                    if (active) begin
                        n_s1.colour = bars_col;
                    end
                end
                MODE_HRAMP, MODE_VRAMP: n_s1.ramp = active;
                MODE_CHECK8: begin
                    if (active && !(ax[3] ^ y[3])) begin
                        n_s1.colour = COL_WHITE;
                    end
                end
                MODE_CHECK16: begin
                    if (active && !(ax[4] ^ y[4])) begin
                        n_s1.colour = COL_WHITE;
                    end
                end
                MODE_XHATCH: begin
                    if (active && grid_hit) begin
                        n_s1.colour = COL_WHITE;
                    end
                end
                default: n_s1.colour = COL_BLACK;
            endcase
        end

        // numerator 2*876*pos + span
        pos      = n_s1.vert ? X_W'(y) : ax;
        n_s1.num = N_W'(pos) * N_W'(2 * RAMP_SCALE)
                 + (n_s1.vert ? N_W'(SPAN_V) : N_W'(SPAN_H));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

// File: rtl/core/ntp_ramp_div.sv
// Two-stage reciprocal divider for the ramp quotient (estimate, then back-multiply).
module ntp_ramp_div
    import ntp_pkg::*;
(
    input  logic    i_clk,
    input  t_div_en i_en,
    input  t_s1     i_s1,
    output t_s3     o_s3
);

    t_s2 r_s2;
    t_s2 n_s2;
    t_s3 r_s3;
    t_s3 n_s3;

    logic [M_W-1:0] recip;

    always_comb begin
        recip       = i_s1.vert ? M_W'(RECIP_V) : M_W'(RECIP_H);
        n_s2.ramp   = i_s1.ramp;
        n_s2.vert   = i_s1.vert;
        n_s2.num    = i_s1.num;
        n_s2.colour = i_s1.colour;
        n_s2.prod   = P_W'(i_s1.num) * P_W'(recip);
    end

    // quotient estimate is exact or one short
    always_comb begin
        n_s3.ramp   = r_s2.ramp;
        n_s3.vert   = r_s2.vert;
        n_s3.num    = r_s2.num;
        n_s3.colour = r_s2.colour;
        n_s3.q_est  = r_s2.prod[RECIP_SHIFT +: Q_W];
        n_s3.qd     = N_W'(n_s3.q_est) * N_W'(ramp_div(r_s2.vert));
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_s2 <= n_s2;
        end
        if (i_en.s3) begin
            r_s3 <= n_s3;
        end
    end

    assign o_s3 = r_s3;

endmodule

// File: rtl/core/ntsc_test_pattern_pixel.sv
// Top level of the NTSC test pattern pixel generator: handshakes, valid pipeline, output stage.
//
//  channel | direction | signals                               | payload
//  --------+-----------+---------------------------------------+--------------------------
//  in      | to block  | i_in_valid, o_in_ready, i_in_data     | pixel_x, pixel_y
//  out     | from block| o_out_valid, i_out_ready, o_out_data  | luma, chroma_blue, chroma_red
//  cfg     | to block  | i_cfg_valid, o_cfg_ready, i_cfg_data  | pattern_mode
//
// One item per clock sustained while the output is taken; four register stages (classify,
// reciprocal multiply, back-multiply, correct and clamp into the output register), and
// o_out_valid rises once an accepted item reaches the output register.
// Every stage has its own valid bit and loads when it is empty or its successor moves, so
// bubbles close up and a held output stalls only the stages behind it.
// Reset (i_rst_n low, synchronous) empties the pipeline and selects 100% bars.
// The cfg port is always ready; pattern_mode is read by the first stage.
module ntsc_test_pattern_pixel
    import ntp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_pix_in           i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_pix_out          o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [MODE_W-1:0] i_cfg_data
);

    logic [MODE_W-1:0] r_mode;
    logic              r_v1;
    logic              r_v2;
    logic              r_v3;
    logic              r_out_valid;
    t_pix_out          r_out;
    t_pix_out          n_out;

    logic    s1_en;
    logic    s2_en;
    logic    s3_en;
    logic    out_en;
    t_div_en div_en;
    t_s1     s1;
    t_s3     s3;

    logic [N_W-1:0] rem;
    logic [N_W-1:0] dv;
    logic [Q_W-1:0] q;
    t_pix_out       pick;

    // a stage loads when empty or when the next one moves
    assign out_en     = !r_out_valid || i_out_ready;
    assign s3_en      = !r_v3 || out_en;
    assign s2_en      = !r_v2 || s3_en;
    assign s1_en      = !r_v1 || s2_en;
    assign div_en.s2  = s2_en;
    assign div_en.s3  = s3_en;
    assign o_in_ready = s1_en;
    assign o_cfg_ready = 1'b1;

    ntp_classify u_classify (
        .i_clk  (i_clk),
        .i_en   (s1_en),
        .i_mode (r_mode),
        .i_pix  (i_in_data),
        .o_s1   (s1)
    );

    ntp_ramp_div u_ramp_div (
        .i_clk (i_clk),
        .i_en  (div_en),
        .i_s1  (s1),
        .o_s3  (s3)
    );

    function automatic logic [C_W-1:0] clamp_code(input logic [C_W-1:0] v,
                                                 input logic [C_W-1:0] lo,
                                                 input logic [C_W-1:0] hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // final correction: remainder at or above the divisor means one more
    always_comb begin
        dv   = N_W'(ramp_div(s3.vert));
        rem  = s3.num - s3.qd;
        q    = s3.q_est + Q_W'(rem >= dv);
        pick = s3.colour;
        if (s3.ramp) begin
            pick = '{C_W'(RAMP_BASE) + C_W'(q), CHROMA_ZERO, CHROMA_ZERO};
        end
        n_out.luma        = clamp_code(pick.luma, LUMA_MIN, LUMA_MAX);
        n_out.chroma_blue = clamp_code(pick.chroma_blue, CHROMA_MIN, CHROMA_MAX);
        n_out.chroma_red  = clamp_code(pick.chroma_red, CHROMA_MIN, CHROMA_MAX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_BARS100;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_en) begin
                r_v1 <= i_in_valid;
            end
            if (s2_en) begin
                r_v2 <= r_v1;
            end
            if (s3_en) begin
                r_v3 <= r_v2;
            end
            if (out_en) begin
                r_out_valid <= r_v3;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    // the reciprocal estimate is never more than one short
    a_recip_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && s3.ramp) |-> (rem < N_W'(2 * ramp_div(s3.vert))))
        else $error("ramp quotient estimate off by more than one");

    // only the bar patterns carry colour
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_mode >= MODE_HRAMP)) |->
        (o_out_data.chroma_blue == CHROMA_ZERO && o_out_data.chroma_red == CHROMA_ZERO))
        else $error("chroma off neutral in a grey pattern");

    // input back-pressure only when the whole pipe is full and the output is held
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready && r_v1 && r_v2 && r_v3))
        else $error("input stalled with room in the pipeline");
`endif

endmodule
